// ===== rtl/lcrs_pkg.sv =====
package lcrs_pkg;

    // Image geometry. Columns beyond the 120 carried by the input fields read as 0.
    localparam int SCAN_WIDTH = 120;
    localparam int COL_W      = $clog2(SCAN_WIDTH);
    localparam int LAST_COL   = SCAN_WIDTH - 1;
    localparam int MID_COL    = SCAN_WIDTH / 2;
    localparam int IN_COLS    = 120;
    localparam int LO_BITS    = 64;
    localparam int HI_BITS    = 56;
    localparam int ROW_W      = 7;

    // The edge search is split into groups of eight columns.
    localparam int GRP_SIZE = 8;
    localparam int SUB_W    = $clog2(GRP_SIZE);
    localparam int GRP_NUM  = (SCAN_WIDTH + GRP_SIZE - 1) / GRP_SIZE;

    // Row codes and weight bands.
    localparam logic [ROW_W-1:0] ROW_FRAME_START = 7'd119;
    localparam logic [ROW_W-1:0] ROW_FRAME_END   = 7'd2;
    localparam logic [ROW_W-1:0] ROW_BAND_HI     = 7'd89;
    localparam logic [ROW_W-1:0] ROW_BAND_MID    = 7'd49;
    localparam logic [ROW_W-1:0] ROW_BAND_LO     = 7'd19;

    localparam int WGT_W = 3;
    localparam logic [WGT_W-1:0] WGT_HI   = 3'd6;
    localparam logic [WGT_W-1:0] WGT_MID  = 3'd4;
    localparam logic [WGT_W-1:0] WGT_LO   = 3'd2;
    localparam logic [WGT_W-1:0] WGT_NONE = 3'd0;

    // Offset arithmetic, in tenths before the division by ten.
    localparam int OFS_W  = 13;
    localparam int DIFF_W = COL_W + 1;
    localparam int PROD_W = DIFF_W + WGT_W + 1;
    localparam int SUM_W  = OFS_W + 4;
    localparam int MAG_W  = SUM_W - 1;

    localparam logic signed [SUM_W-1:0] TEN_S   = 17'sd10;
    localparam logic [OFS_W-1:0]        OFS_MAX = 13'd4095;
    localparam logic [OFS_W-1:0]        OFS_MIN = 13'h1000;

    // x / 10 equals (x * 52429) >> 19 for every x below 81920.
    localparam int DIV10_SHIFT = 19;
    localparam logic [MAG_W-1:0] DIV10_MUL = 16'd52429;

    typedef struct packed {
        logic load;
        logic grp;
        logic merge;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

    function automatic logic [WGT_W-1:0] row_weight(input logic [ROW_W-1:0] row);
        logic [WGT_W-1:0] w;
        if (row > ROW_BAND_HI && row <= ROW_FRAME_START) begin
            w = WGT_HI;
        end else if (row > ROW_BAND_MID && row <= ROW_BAND_HI) begin
            w = WGT_MID;
        end else if (row > ROW_BAND_LO && row <= ROW_BAND_MID) begin
            w = WGT_LO;
        end else begin
            w = WGT_NONE;
        end
        return w;
    endfunction

endpackage

// ===== rtl/lcrs_ifs.sv =====
interface lcrs_in_if;
    logic        valid;
    logic        ready;
    logic [6:0]  row_number;
    logic [63:0] pixels_low;
    logic [55:0] pixels_high;

    modport source (output valid, output row_number, output pixels_low,
                    output pixels_high, input ready);
    modport sink   (input valid, input row_number, input pixels_low,
                    input pixels_high, output ready);
endinterface

interface lcrs_out_if;
    logic              valid;
    logic              ready;
    logic [6:0]        left_edge;
    logic [6:0]        right_edge;
    logic [6:0]        center;
    logic signed [12:0] steer_offset;
    logic              frame_done;

    modport source (output valid, output left_edge, output right_edge, output center,
                    output steer_offset, output frame_done, input ready);
    modport sink   (input valid, input left_edge, input right_edge, input center,
                    input steer_offset, input frame_done, output ready);
endinterface

// ===== rtl/lane_center_row_scanner.sv =====
// Channel  Direction  Payload                                              Handshake
// i_in     sink       row_number, pixels_low, pixels_high                  valid / ready
// o_out    source     left_edge, right_edge, center, steer_offset,         valid / ready
//                     frame_done
//
// Each row passes through four steps: one to capture the transaction, one for the per-group
// edge encoders, one to merge the groups and form the weighted sum, and one for the
// division by ten and saturation, which also loads the output register.
// The last of these waits while a previous result has not yet been taken, so a stalled sink
// holds back the row; a new row can be captured while a committed result waits, but not while the divide step waits.
// Reset is synchronous and active low: both start columns return to 60 and the
// accumulated offset to zero.
module lane_center_row_scanner (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lcrs_in_if.sink         i_in,
    lcrs_out_if.source      o_out
);

    // Commands from the sequencer and status back from the datapath.
    lcrs_pkg::t_cmd w_cmd;
    lcrs_pkg::t_sts w_sts;
    logic           w_in_ready;

    // The sequencer walks capture, group encode, merge and divide, and holds the
    // divide step until the output register is free.
    lcrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    // The datapath holds the start columns and the running offset, which are
    // updated only when a row's result is committed to the output register.
    lcrs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_row_number   (i_in.row_number),
        .i_pixels_low   (i_in.pixels_low),
        .i_pixels_high  (i_in.pixels_high),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_left_edge    (o_out.left_edge),
        .o_right_edge   (o_out.right_edge),
        .o_center       (o_out.center),
        .o_steer_offset (o_out.steer_offset),
        .o_frame_done   (o_out.frame_done)
    );

endmodule

// ===== rtl/lcrs_ctrl.sv =====
module lcrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lcrs_pkg::t_sts i_sts,
    output lcrs_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_GRP   = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_GRP;
                end
            end
            S_GRP:   n_state = S_MERGE;
            S_MERGE: n_state = S_DIV;
            S_DIV: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.grp    = (r_state == S_GRP);
    assign o_cmd.merge  = (r_state == S_MERGE);
    assign o_cmd.commit = (r_state == S_DIV) && !i_sts.out_busy;

endmodule

// ===== rtl/lcrs_dp.sv =====
module lcrs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lcrs_pkg::t_cmd                      i_cmd,
    output lcrs_pkg::t_sts                      o_sts,
    input  logic [lcrs_pkg::ROW_W-1:0]          i_row_number,
    input  logic [lcrs_pkg::LO_BITS-1:0]        i_pixels_low,
    input  logic [lcrs_pkg::HI_BITS-1:0]        i_pixels_high,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lcrs_pkg::COL_W-1:0]          o_left_edge,
    output logic [lcrs_pkg::COL_W-1:0]          o_right_edge,
    output logic [lcrs_pkg::COL_W-1:0]          o_center,
    output logic signed [lcrs_pkg::OFS_W-1:0]   o_steer_offset,
    output logic                                o_frame_done
);

    // Persistent state.
    logic [lcrs_pkg::COL_W-1:0]        r_search_start;
    logic [lcrs_pkg::COL_W-1:0]        r_bottom_center;
    logic signed [lcrs_pkg::OFS_W-1:0] r_offset_sum;

    // Captured item.
    logic [lcrs_pkg::ROW_W-1:0]        r_row;
    logic [lcrs_pkg::SCAN_WIDTH-1:0]   r_pix;
    logic [lcrs_pkg::COL_W-1:0]        r_start;
    logic [lcrs_pkg::SCAN_WIDTH-1:0]   n_pix;
    logic [lcrs_pkg::IN_COLS-1:0]      w_in_cols;

    // Group encoder results.
    logic [lcrs_pkg::GRP_NUM-1:0]      r_l_any, n_l_any;
    logic [lcrs_pkg::GRP_NUM-1:0]      r_r_any, n_r_any;
    logic [lcrs_pkg::SUB_W-1:0]        r_l_sub [lcrs_pkg::GRP_NUM];
    logic [lcrs_pkg::SUB_W-1:0]        r_r_sub [lcrs_pkg::GRP_NUM];
    logic [lcrs_pkg::SUB_W-1:0]        n_l_sub [lcrs_pkg::GRP_NUM];
    logic [lcrs_pkg::SUB_W-1:0]        n_r_sub [lcrs_pkg::GRP_NUM];
    logic [lcrs_pkg::SCAN_WIDTH-1:0]   w_diff;

    // Merge stage.
    logic [lcrs_pkg::COL_W-1:0]        r_left, r_right, r_center;
    logic [lcrs_pkg::COL_W-1:0]        n_left, n_right, n_center;
    logic [lcrs_pkg::COL_W:0]          w_edge_sum;
    logic signed [lcrs_pkg::DIFF_W-1:0] w_diff_mid;
    logic signed [lcrs_pkg::PROD_W-1:0] w_wprod;
    logic signed [lcrs_pkg::SUM_W-1:0]  w_base;
    logic signed [lcrs_pkg::SUM_W-1:0]  n_t;
    logic                               r_neg;
    logic [lcrs_pkg::MAG_W-1:0]         r_mag;
    logic [lcrs_pkg::MAG_W-1:0]         n_mag;

    // Divide stage.
    logic [2*lcrs_pkg::MAG_W-1:0]      w_quot_prod;
    logic [lcrs_pkg::OFS_W-1:0]        w_quot;
    logic [lcrs_pkg::OFS_W-1:0]        n_offset;

    // Output register.
    logic                              r_out_valid;
    logic [lcrs_pkg::COL_W-1:0]        r_o_left, r_o_right, r_o_center;
    logic signed [lcrs_pkg::OFS_W-1:0] r_o_offset;
    logic                              r_o_done;

    assign w_in_cols = {i_pixels_high, i_pixels_low};

    always_comb begin
        for (int k = 0; k < lcrs_pkg::SCAN_WIDTH; k++) begin
            if (k < lcrs_pkg::IN_COLS) begin
                n_pix[k] = w_in_cols[k];
            end else begin
                n_pix[k] = 1'b0;
            end
        end
    end

    // Transition flags: bit j is set where column j differs from column j-1.
    always_comb begin
        w_diff[0] = 1'b0;
        for (int j = 1; j < lcrs_pkg::SCAN_WIDTH; j++) begin
            w_diff[j] = r_pix[j] ^ r_pix[j-1];
        end
    end

    // Per group: highest left candidate and lowest right candidate.
    always_comb begin
        int col;
        for (int g = 0; g < lcrs_pkg::GRP_NUM; g++) begin
            n_l_any[g] = 1'b0;
            n_r_any[g] = 1'b0;
            n_l_sub[g] = '0;
            n_r_sub[g] = '0;
            for (int b = 0; b < lcrs_pkg::GRP_SIZE; b++) begin
                col = g * lcrs_pkg::GRP_SIZE + b;
                if (col >= 2 && col < lcrs_pkg::SCAN_WIDTH && col <= int'(r_start)) begin
                    if (w_diff[col]) begin
                        n_l_any[g] = 1'b1;
                        n_l_sub[g] = lcrs_pkg::SUB_W'(b);
                    end
                end
            end
            for (int b = lcrs_pkg::GRP_SIZE - 1; b >= 0; b--) begin
                col = g * lcrs_pkg::GRP_SIZE + b;
                if (col <= lcrs_pkg::SCAN_WIDTH - 2 && col >= int'(r_start)) begin
                    if (w_diff[col+1]) begin
                        n_r_any[g] = 1'b1;
                        n_r_sub[g] = lcrs_pkg::SUB_W'(b);
                    end
                end
            end
        end
    end

    // Merge across groups, form the centre and the weighted sum in tenths.
    always_comb begin
        n_left  = '0;
        n_right = lcrs_pkg::COL_W'(lcrs_pkg::LAST_COL);
        for (int g = 0; g < lcrs_pkg::GRP_NUM; g++) begin
            if (r_l_any[g]) begin
                n_left = lcrs_pkg::COL_W'(g * lcrs_pkg::GRP_SIZE) + lcrs_pkg::COL_W'(r_l_sub[g]);
            end
        end
        for (int g = lcrs_pkg::GRP_NUM - 1; g >= 0; g--) begin
            if (r_r_any[g]) begin
                n_right = lcrs_pkg::COL_W'(g * lcrs_pkg::GRP_SIZE) + lcrs_pkg::COL_W'(r_r_sub[g]);
            end
        end
        w_edge_sum = {1'b0, n_left} + {1'b0, n_right};
        n_center   = w_edge_sum[lcrs_pkg::COL_W:1];
        w_diff_mid = $signed(lcrs_pkg::DIFF_W'(lcrs_pkg::MID_COL)) - $signed({1'b0, n_center});
        w_wprod    = lcrs_pkg::PROD_W'(w_diff_mid)
                     * $signed(lcrs_pkg::PROD_W'(lcrs_pkg::row_weight(r_row)));
        if (r_row == lcrs_pkg::ROW_FRAME_START) begin
            w_base = '0;
        end else begin
            w_base = lcrs_pkg::SUM_W'(r_offset_sum) * lcrs_pkg::TEN_S;
        end
        n_t   = w_base + lcrs_pkg::SUM_W'(w_wprod);
        n_mag = n_t[lcrs_pkg::SUM_W-1] ? lcrs_pkg::MAG_W'(-n_t) : lcrs_pkg::MAG_W'(n_t);
    end

    // Truncating division by ten on the magnitude, then sign and saturation.
    always_comb begin
        w_quot_prod = {{lcrs_pkg::MAG_W{1'b0}}, r_mag}
                      * {{lcrs_pkg::MAG_W{1'b0}}, lcrs_pkg::DIV10_MUL};
        w_quot = w_quot_prod[lcrs_pkg::DIV10_SHIFT +: lcrs_pkg::OFS_W];
        if (!r_neg) begin
            n_offset = (w_quot > lcrs_pkg::OFS_MAX) ? lcrs_pkg::OFS_MAX : w_quot;
        end else begin
            n_offset = (w_quot > lcrs_pkg::OFS_MIN) ? lcrs_pkg::OFS_MIN : (~w_quot + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row <= i_row_number;
            r_pix <= n_pix;
            r_start <= (i_row_number == lcrs_pkg::ROW_FRAME_START) ? r_bottom_center
                                                                    : r_search_start;
        end
        if (i_cmd.grp) begin
            r_l_any <= n_l_any;
            r_r_any <= n_r_any;
            r_l_sub <= n_l_sub;
            r_r_sub <= n_r_sub;
        end
        if (i_cmd.merge) begin
            r_left   <= n_left;
            r_right  <= n_right;
            r_center <= n_center;
            r_neg    <= n_t[lcrs_pkg::SUM_W-1];
            r_mag    <= n_mag;
        end
        if (i_cmd.commit) begin
            r_o_left   <= r_left;
            r_o_right  <= r_right;
            r_o_center <= r_center;
            r_o_offset <= $signed(n_offset);
            r_o_done   <= (r_row == lcrs_pkg::ROW_FRAME_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_start  <= lcrs_pkg::COL_W'(lcrs_pkg::MID_COL);
            r_bottom_center <= lcrs_pkg::COL_W'(lcrs_pkg::MID_COL);
            r_offset_sum    <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_search_start <= r_center;
                r_offset_sum   <= $signed(n_offset);
                if (r_row == lcrs_pkg::ROW_FRAME_START) begin
                    r_bottom_center <= r_center;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_left_edge    = r_o_left;
    assign o_right_edge   = r_o_right;
    assign o_center       = r_o_center;
    assign o_steer_offset = r_o_offset;
    assign o_frame_done   = r_o_done;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_valid && !i_out_ready))
        else $error("result overwritten while still waiting");

    a_edge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_left <= r_o_right))
        else $error("left edge lies right of right edge");

    a_center_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_center >= r_o_left && r_o_center <= r_o_right))
        else $error("centre outside its edges");

    a_start_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_search_start == r_o_center))
        else $error("search start not taken from the last centre");
`endif

endmodule
